// ===== hw/rtl/itp_pkg.sv =====
// shared constants, codes, types and helpers for the infix to postfix converter
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VALUE_WIDTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // request kinds
    localparam logic [1:0] REQ_NUM    = 2'd0;
    localparam logic [1:0] REQ_OP     = 2'd1;
    localparam logic [1:0] REQ_LPAREN = 2'd2;
    localparam logic [1:0] REQ_RPAREN = 2'd3;

    // result kinds
    localparam logic [1:0] OUT_NUM    = 2'd0;
    localparam logic [1:0] OUT_OP     = 2'd1;
    localparam logic [1:0] OUT_LPAREN = 2'd2;

    // operator codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    // stack entry: bit 3 marks a left paren
    localparam logic [3:0] ENTRY_PAREN = 4'b1000;

    typedef logic [3:0] entry_t;

    typedef struct packed {
        logic accept;
        logic emit_num;
        logic emit_top;
        logic pop_only;
        logic push;
        logic finish;
        logic clear_flag;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       last;
        logic       top_valid;
        logic       top_paren;
        logic       top_ge;
        logic       pend_valid;
        logic       out_free;
    } ctl_status_t;

    function automatic logic [1:0] prec_of(input logic [2:0] code);
        logic [1:0] p;
        case (code)
            OP_ADD, OP_SUB: p = 2'd1;
            OP_MUL, OP_DIV: p = 2'd2;
            OP_POW:         p = 2'd3;
            default:        p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/itp_datapath.sv =====
// operator stack, request registers, pending result and output register
module itp_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [1:0]                        s_req_type,
    input  logic [2:0]                        s_op_code,
    input  logic [itp_pkg::VALUE_WIDTH-1:0]   s_num_value,
    input  logic                              s_is_last,
    input  itp_pkg::ctl_cmd_t                 cmd,
    output itp_pkg::ctl_status_t              status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_out_kind,
    output logic [2:0]                        m_out_op,
    output logic [itp_pkg::VALUE_WIDTH-1:0]   m_out_value,
    output logic                              m_expr_done,
    output logic                              m_run_last,
    output logic                              m_overflow_seen
);

    // latched request
    logic [1:0]                      kind_reg;
    logic [2:0]                      code_reg;
    logic [itp_pkg::VALUE_WIDTH-1:0] value_reg;
    logic                            last_reg;

    // stack
    itp_pkg::entry_t                 stack_reg [itp_pkg::STACK_DEPTH];
    logic [itp_pkg::CNT_W-1:0]       count_reg;
    logic [itp_pkg::CNT_W-1:0]       count_next;
    logic                            ovf_reg;
    logic                            ovf_next;

    // pending result
    logic                            pend_valid_reg;
    logic                            pend_valid_next;
    logic [1:0]                      pend_kind_reg;
    logic [2:0]                      pend_op_reg;
    logic [itp_pkg::VALUE_WIDTH-1:0] pend_value_reg;
    logic                            pend_ovf_reg;

    // output register
    logic                            out_valid_reg;
    logic [1:0]                      out_kind_reg;
    logic [2:0]                      out_op_reg;
    logic [itp_pkg::VALUE_WIDTH-1:0] out_value_reg;
    logic                            out_done_reg;
    logic                            out_last_reg;
    logic                            out_ovf_reg;

    logic [itp_pkg::CNT_W-1:0]       top_pos;
    logic [itp_pkg::IDX_W-1:0]       top_addr;
    itp_pkg::entry_t                 top_entry;
    logic                            full;
    logic                            new_result;
    logic                            move;
    itp_pkg::entry_t                 push_entry;

    assign top_pos    = count_reg - itp_pkg::CNT_W'(1);
    assign top_addr   = top_pos[itp_pkg::IDX_W-1:0];
    assign top_entry  = stack_reg[top_addr];
    assign full       = (count_reg == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
    assign new_result = cmd.emit_num | cmd.emit_top;
    assign move       = pend_valid_reg & (new_result | cmd.finish);
    assign push_entry = (kind_reg == itp_pkg::REQ_LPAREN) ? itp_pkg::ENTRY_PAREN
                                                           : {1'b0, code_reg};

    always_comb begin
        status.kind       = kind_reg;
        status.last       = last_reg;
        status.top_valid  = (count_reg != '0);
        status.top_paren  = top_entry[3];
        status.top_ge     = (itp_pkg::prec_of(top_entry[2:0]) >= itp_pkg::prec_of(code_reg));
        status.pend_valid = pend_valid_reg;
        status.out_free   = ~out_valid_reg | m_ready;
    end

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.emit_top || cmd.pop_only) begin
            count_next = top_pos;
        end else if (cmd.push) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + itp_pkg::CNT_W'(1);
            end
        end
        if (cmd.clear_flag) begin
            ovf_next = 1'b0;
        end
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (new_result) begin
            pend_valid_next = 1'b1;
        end else if (cmd.finish) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg  <= s_req_type;
            code_reg  <= s_op_code;
            value_reg <= s_num_value;
            last_reg  <= s_is_last;
        end
        if (cmd.push && !full) begin
            stack_reg[count_reg[itp_pkg::IDX_W-1:0]] <= push_entry;
        end
        if (cmd.emit_num) begin
            pend_kind_reg  <= itp_pkg::OUT_NUM;
            pend_op_reg    <= '0;
            pend_value_reg <= value_reg;
            pend_ovf_reg   <= ovf_reg;
        end else if (cmd.emit_top) begin
            pend_kind_reg  <= top_entry[3] ? itp_pkg::OUT_LPAREN : itp_pkg::OUT_OP;
            pend_op_reg    <= top_entry[3] ? 3'd0 : top_entry[2:0];
            pend_value_reg <= '0;
            pend_ovf_reg   <= ovf_reg;
        end
        if (move) begin
            out_kind_reg  <= pend_kind_reg;
            out_op_reg    <= pend_op_reg;
            out_value_reg <= pend_value_reg;
            out_ovf_reg   <= pend_ovf_reg;
            out_last_reg  <= cmd.finish;
            out_done_reg  <= cmd.finish & last_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_kind      = out_kind_reg;
    assign m_out_op        = out_op_reg;
    assign m_out_value     = out_value_reg;
    assign m_expr_done     = out_done_reg;
    assign m_run_last      = out_last_reg;
    assign m_overflow_seen = out_ovf_reg;

endmodule

// ===== hw/rtl/itp_ctrl.sv =====
// controller state machine sequencing pops, pushes, flush and result release
module itp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  itp_pkg::ctl_status_t status,
    output itp_pkg::ctl_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROC  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       can_emit;
    logic [1:0] after_item;

    assign can_emit   = ~status.pend_valid | status.out_free;
    assign after_item = status.last ? ST_FLUSH : ST_FIN;
    assign s_ready    = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PROC;
                end
            end
            ST_PROC: begin
                case (status.kind)
                    itp_pkg::REQ_NUM: begin
                        if (can_emit) begin
                            cmd.emit_num = 1'b1;
                            state_next   = after_item;
                        end
                    end
                    itp_pkg::REQ_OP: begin
                        if (status.top_valid && !status.top_paren && status.top_ge) begin
                            cmd.emit_top = can_emit;
                        end else begin
                            cmd.push   = 1'b1;
                            state_next = after_item;
                        end
                    end
                    itp_pkg::REQ_LPAREN: begin
                        cmd.push   = 1'b1;
                        state_next = after_item;
                    end
                    default: begin
                        if (status.top_valid && !status.top_paren) begin
                            cmd.emit_top = can_emit;
                        end else begin
                            cmd.pop_only = status.top_valid;
                            state_next   = after_item;
                        end
                    end
                endcase
            end
            ST_FLUSH: begin
                if (status.top_valid) begin
                    cmd.emit_top = can_emit;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (can_emit) begin
                    cmd.finish     = 1'b1;
                    cmd.clear_flag = status.last;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/infix_to_postfix_converter.sv =====
// top level of the shunting-yard infix to postfix converter
//
// input channel (s_*): one infix token per request, number, operator,
// left paren or right paren, with s_is_last marking the final token.
// output channel (m_*): postfix tokens in order, one per transfer, with
// m_run_last on the last token a request causes and m_expr_done on the
// final token of an expression. m_overflow_seen reports a push dropped
// on a full operator stack since the last flush.
// one request is worked at a time: after it is taken, operators are popped
// one per step through the single stack read port, and a request marked
// last then flushes the stack before its result is released. a result
// passes the pending register and then the output register on its way
// to m_valid.
// the output register lets the next request be taken while a token waits.
// if the receiver stalls, pops halt once one token is held pending and
// one waits in the output register; nothing is lost.
// reset (aresetn low, synchronous) empties the stack, clears the overflow
// flag and drops any token held.
module infix_to_postfix_converter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [2:0]                        s_op_code,
    input  logic [itp_pkg::VALUE_WIDTH-1:0]   s_num_value,
    input  logic                              s_is_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_out_kind,
    output logic [2:0]                        m_out_op,
    output logic [itp_pkg::VALUE_WIDTH-1:0]   m_out_value,
    output logic                              m_expr_done,
    output logic                              m_run_last,
    output logic                              m_overflow_seen
);

    itp_pkg::ctl_cmd_t    cmd;
    itp_pkg::ctl_status_t status;

    itp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    itp_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_req_type      (s_req_type),
        .s_op_code       (s_op_code),
        .s_num_value     (s_num_value),
        .s_is_last       (s_is_last),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_kind      (m_out_kind),
        .m_out_op        (m_out_op),
        .m_out_value     (m_out_value),
        .m_expr_done     (m_expr_done),
        .m_run_last      (m_run_last),
        .m_overflow_seen (m_overflow_seen)
    );

endmodule

// ===== hw/rtl/itp_checker.sv =====
// port-level checks of the converter and their binding to the top level
module itp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [1:0]                        s_req_type,
    input logic [2:0]                        s_op_code,
    input logic [itp_pkg::VALUE_WIDTH-1:0]   s_num_value,
    input logic                              s_is_last,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [1:0]                        m_out_kind,
    input logic [2:0]                        m_out_op,
    input logic [itp_pkg::VALUE_WIDTH-1:0]   m_out_value,
    input logic                              m_expr_done,
    input logic                              m_run_last,
    input logic                              m_overflow_seen
);

    // stalled request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_req_type) && $stable(s_op_code)
            && $stable(s_num_value) && $stable(s_is_last))
        else $error("request changed while stalled");

    // stalled output holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_kind) && $stable(m_out_op)
            && $stable(m_out_value) && $stable(m_run_last) && $stable(m_expr_done)
            && $stable(m_overflow_seen))
        else $error("output changed while stalled");

    // end of expression is also end of its request
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_expr_done |-> m_run_last)
        else $error("expr_done without run_last");

    // only number tokens carry a value, only operators a code
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_kind == itp_pkg::OUT_NUM || m_out_value == '0)
            && (m_out_kind == itp_pkg::OUT_OP || m_out_op == 3'd0))
        else $error("stray payload bits");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

// ===== test/tb_infix_to_postfix_converter.sv =====
// testbench for the infix to postfix converter: directed table and random expressions
`timescale 1ns / 100ps

module tb_infix_to_postfix_converter;

    localparam int N_DIRECTED     = 42;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 110;
    localparam int IDLE_TAB  [4]  = '{0, 47, 0, 24};
    localparam int STALL_TAB [4]  = '{0, 0, 47, 24};

    typedef struct packed {
        logic [1:0]                      kind;
        logic [2:0]                      op;
        logic [itp_pkg::VALUE_WIDTH-1:0] value;
        logic                            done;
        logic                            run_last;
        logic                            ovf;
    } postfix_tok_t;

    typedef struct packed {
        logic [1:0]                      kind;
        logic [2:0]                      code;
        logic [itp_pkg::VALUE_WIDTH-1:0] value;
        logic                            last;
        int                              reps;
        logic                            typed;
        logic                            exp_done;
        logic                            exp_ovf;
    } stim_row_t;

    typedef struct packed {
        logic         typed;
        postfix_tok_t tok;
    } req_note_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [1:0]                      s_req_type;
    logic [2:0]                      s_op_code;
    logic [itp_pkg::VALUE_WIDTH-1:0] s_num_value;
    logic                            s_is_last;
    logic                            m_valid;
    logic                            m_ready;
    logic [1:0]                      m_out_kind;
    logic [2:0]                      m_out_op;
    logic [itp_pkg::VALUE_WIDTH-1:0] m_out_value;
    logic                            m_expr_done;
    logic                            m_run_last;
    logic                            m_overflow_seen;

    infix_to_postfix_converter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_op_code       (s_op_code),
        .s_num_value     (s_num_value),
        .s_is_last       (s_is_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_kind      (m_out_kind),
        .m_out_op        (m_out_op),
        .m_out_value     (m_out_value),
        .m_expr_done     (m_expr_done),
        .m_run_last      (m_run_last),
        .m_overflow_seen (m_overflow_seen)
    );

    always #2 aclk = ~aclk;

    // operator stack mirror
    itp_pkg::entry_t opstk [itp_pkg::STACK_DEPTH];
    int unsigned     stk_cnt = 0;
    logic            ovf_flag = 1'b0;

    postfix_tok_t item_tokens [$];
    postfix_tok_t postfix_q [$];
    req_note_t    req_notes [$];
    req_note_t    note_now;
    postfix_tok_t want_tok;

    int  mismatch_cnt   = 0;
    int  quiet_cycles   = 0;
    int  sent_count     = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  rx_hold_req    = 1'b0;

    stim_row_t directed_rows [N_DIRECTED];

    function automatic logic [1:0] op_rank(logic [2:0] code);
        if (code == itp_pkg::OP_POW) return 2'd3;
        if (code == itp_pkg::OP_MUL || code == itp_pkg::OP_DIV) return 2'd2;
        if (code == itp_pkg::OP_ADD || code == itp_pkg::OP_SUB) return 2'd1;
        return 2'd0;
    endfunction

    function automatic postfix_tok_t entry_tok(itp_pkg::entry_t e);
        postfix_tok_t t;
        t = '0;
        if ((e & itp_pkg::ENTRY_PAREN) != 0) begin
            t.kind = itp_pkg::OUT_LPAREN;
        end else begin
            t.kind = itp_pkg::OUT_OP;
            t.op   = e[2:0];
        end
        return t;
    endfunction

    function automatic void push_entry(itp_pkg::entry_t e);
        if (stk_cnt < itp_pkg::STACK_DEPTH) begin
            opstk[stk_cnt] = e;
            stk_cnt++;
        end else begin
            ovf_flag = 1'b1;
        end
    endfunction

    // postfix tokens caused by one request, into item_tokens
    function automatic void shunt_request(logic [1:0] kind, logic [2:0] code,
                                          logic [itp_pkg::VALUE_WIDTH-1:0] value,
                                          logic last);
        postfix_tok_t    t;
        itp_pkg::entry_t top;
        item_tokens.delete();
        case (kind)
            itp_pkg::REQ_NUM: begin
                t = '0;
                t.kind  = itp_pkg::OUT_NUM;
                t.value = value;
                item_tokens.insert(item_tokens.size(), t);
            end
            itp_pkg::REQ_OP: begin
                while (stk_cnt > 0) begin
                    top = opstk[stk_cnt - 1];
                    if ((top & itp_pkg::ENTRY_PAREN) != 0 || op_rank(top[2:0]) < op_rank(code))
                        break;
                    item_tokens.insert(item_tokens.size(), entry_tok(top));
                    stk_cnt--;
                end
                push_entry({1'b0, code});
            end
            itp_pkg::REQ_LPAREN: begin
                push_entry(itp_pkg::ENTRY_PAREN);
            end
            default: begin
                while (stk_cnt > 0) begin
                    top = opstk[stk_cnt - 1];
                    stk_cnt--;
                    if ((top & itp_pkg::ENTRY_PAREN) != 0) break;
                    item_tokens.insert(item_tokens.size(), entry_tok(top));
                end
            end
        endcase
        foreach (item_tokens[i]) item_tokens[i].ovf = ovf_flag;
        if (last) begin
            while (stk_cnt > 0) begin
                t = entry_tok(opstk[stk_cnt - 1]);
                t.ovf = ovf_flag;
                item_tokens.insert(item_tokens.size(), t);
                stk_cnt--;
            end
            ovf_flag = 1'b0;
            if (item_tokens.size() > 0) item_tokens[item_tokens.size() - 1].done = 1'b1;
        end
        if (item_tokens.size() > 0) item_tokens[item_tokens.size() - 1].run_last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (got_v !== want_v) begin
            mismatch_cnt++;
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
        end
    endfunction

    function automatic logic [itp_pkg::VALUE_WIDTH-1:0] rand_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [2:0] rand_op();
        if ($urandom_range(99) < 5) return 3'($urandom_range(7, 5));
        return 3'($urandom_range(4));
    endfunction

    function automatic stim_row_t plain_row(logic [1:0] kind, logic [2:0] code,
                                            logic [itp_pkg::VALUE_WIDTH-1:0] value);
        stim_row_t r;
        r = '0;
        r.kind  = kind;
        r.code  = code;
        r.value = value;
        r.reps  = 1;
        return r;
    endfunction

    function automatic stim_row_t noise_row();
        stim_row_t r;
        r = plain_row(2'($urandom_range(3)), 3'($urandom_range(7)), rand_value());
        r.last = 1'($urandom_range(1));
        return r;
    endfunction

    // accepted requests feed the predictor, accepted tokens are compared
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            note_now = req_notes.pop_front();
            shunt_request(s_req_type, s_op_code, s_num_value, s_is_last);
            if (note_now.typed) begin
                postfix_q.insert(postfix_q.size(), note_now.tok);
            end else begin
                foreach (item_tokens[i]) postfix_q.insert(postfix_q.size(), item_tokens[i]);
            end
        end
        if (m_valid && m_ready) begin
            if (postfix_q.size() == 0) begin
                mismatch_cnt++;
                $error("unexpected token: kind %0d op %0d value %0h",
                       m_out_kind, m_out_op, m_out_value);
            end else begin
                want_tok = postfix_q.pop_front();
                check_field("out_kind", 64'(want_tok.kind), 64'(m_out_kind));
                check_field("out_op", 64'(want_tok.op), 64'(m_out_op));
                check_field("out_value", 64'(want_tok.value), 64'(m_out_value));
                check_field("expr_done", 64'(want_tok.done), 64'(m_expr_done));
                check_field("run_last", 64'(want_tok.run_last), 64'(m_run_last));
                check_field("overflow_seen", 64'(want_tok.ovf), 64'(m_overflow_seen));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_row(stim_row_t row);
        req_note_t nt;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        nt.typed = row.typed;
        nt.tok   = '{itp_pkg::OUT_NUM, 3'd0, row.value, row.exp_done, 1'b1, row.exp_ovf};
        req_notes.insert(req_notes.size(), nt);
        s_valid     <= 1'b1;
        s_req_type  <= row.kind;
        s_op_code   <= row.code;
        s_num_value <= row.value;
        s_is_last   <= row.last;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (postfix_q.size() != 0);
    endtask

    // well-formed expression with random content, sometimes broken
    task automatic send_expression(bit deep);
        stim_row_t expr [$];
        int  max_depth;
        int  paren_pct;
        int  len_target;
        int  depth;
        int  n_ops;
        int  pos;
        bit  want_operand;
        max_depth    = deep ? 40 : 4;
        paren_pct    = deep ? 95 : 25;
        len_target   = deep ? 20 : $urandom_range(6);
        depth        = 0;
        n_ops        = 0;
        want_operand = 1'b1;
        forever begin
            if (want_operand) begin
                if (depth < max_depth && $urandom_range(99) < paren_pct) begin
                    expr.insert(expr.size(),
                                plain_row(itp_pkg::REQ_LPAREN, rand_op(), rand_value()));
                    depth++;
                end else begin
                    expr.insert(expr.size(),
                                plain_row(itp_pkg::REQ_NUM, rand_op(), rand_value()));
                    want_operand = 1'b0;
                end
            end else if (depth > 0 && $urandom_range(99) < 30) begin
                expr.insert(expr.size(), plain_row(itp_pkg::REQ_RPAREN, rand_op(), rand_value()));
                depth--;
            end else if (n_ops >= len_target) begin
                break;
            end else begin
                expr.insert(expr.size(), plain_row(itp_pkg::REQ_OP, rand_op(), rand_value()));
                n_ops++;
                want_operand = 1'b1;
            end
        end
        while (depth > 0) begin
            expr.insert(expr.size(), plain_row(itp_pkg::REQ_RPAREN, rand_op(), rand_value()));
            depth--;
        end
        if ($urandom_range(99) < 12) begin
            pos = $urandom_range(expr.size() - 1);
            case ($urandom_range(2))
                0: expr[pos] = noise_row();
                1: expr.delete(pos);
                default: expr.insert(pos, noise_row());
            endcase
        end
        if (expr.size() > 0 && $urandom_range(99) < 92) expr[expr.size() - 1].last = 1'b1;
        foreach (expr[i]) send_row(expr[i]);
    endtask

    initial begin
        int phase_end;

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_req_type  <= itp_pkg::REQ_NUM;
        s_op_code   <= itp_pkg::OP_ADD;
        s_num_value <= '0;
        s_is_last   <= 1'b0;

        // kind, code, value, last, reps, typed, exp_done, exp_ovf
        directed_rows = '{
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b1, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'hFFFFFFFFFFFFFFFF, 1'b1, 1, 1'b1, 1'b1, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd3, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd5, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, itp_pkg::OP_MUL, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd7, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, itp_pkg::OP_POW, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd2, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, itp_pkg::OP_POW, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd2, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, itp_pkg::OP_SUB, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd9, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, itp_pkg::OP_DIV, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd4, 1'b1, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_LPAREN, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd1, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd2, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_RPAREN, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, itp_pkg::OP_MUL, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_LPAREN, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_LPAREN, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd3, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, 3'd5, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd4, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, 3'd6, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_RPAREN, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_RPAREN, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_RPAREN, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, 3'd7, 64'h0, 1'b1, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_RPAREN, itp_pkg::OP_ADD, 64'h0, 1'b1, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_LPAREN, itp_pkg::OP_ADD, 64'h0, 1'b1, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_LPAREN, itp_pkg::OP_ADD, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'd6, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_OP, itp_pkg::OP_ADD, 64'h0, 1'b1, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_LPAREN, itp_pkg::OP_ADD, 64'h0, 1'b0, 34, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'h8000000000000001, 1'b0, 1, 1'b1, 1'b0, 1'b1},
        '{itp_pkg::REQ_OP, itp_pkg::OP_POW, 64'h0, 1'b0, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_RPAREN, itp_pkg::OP_ADD, 64'h0, 1'b1, 1, 1'b0, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'h5555555555555555, 1'b0, 1, 1'b1, 1'b0, 1'b0},
        '{itp_pkg::REQ_NUM, itp_pkg::OP_ADD, 64'hAAAAAAAAAAAAAAAA, 1'b1, 1, 1'b1, 1'b1, 1'b0}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            repeat (directed_rows[r].reps) send_row(directed_rows[r]);
        end
        wait_for_results();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = IDLE_TAB[ph];
            recv_stall_pct = STALL_TAB[ph];
            // receiver holds off while requests keep coming
            if (ph == 0) rx_hold_req = 1'b1;
            phase_end = sent_count + PHASE_ITEMS;
            while (sent_count < phase_end) send_expression($urandom_range(11) == 0);
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && postfix_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
